@@ sv/asymmetric_curved_glide_macros.svh @@
// Assertion macros shared by the glide block.
`ifndef ASYMMETRIC_CURVED_GLIDE_MACROS_SVH
`define ASYMMETRIC_CURVED_GLIDE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ACG_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition at one edge that forces another at the next edge.
`define ACG_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/acg_pkg.sv @@
// Constants, types and saturation helpers for the glide block.
`timescale 1ns / 1ps
package acg_pkg;

   localparam int CHANNELS_DEF = 16;

   localparam logic [19:0] NMAX        = 20'hFFFFF;
   localparam logic [26:0] LOG2E_Q26   = 27'd96817197;
   localparam logic [29:0] LN2_Q30     = 30'd744261118;
   localparam logic [30:0] ONE_Q       = 31'h4000_0000;
   localparam logic [62:0] EXP_CAP     = 63'h4000_0000_0000_0000;
   localparam logic [13:0] COUNT_DIV   = 14'd16000;
   localparam logic [12:0] COUNT_BIAS  = 13'd8000;
   localparam logic [3:0]  EXP_TERMS   = 4'd12;

   localparam logic signed [15:0] CURVE_RESET = 16'sd0;
   localparam logic [17:0]        RATE_RESET  = 18'd48000;

   // register select, taken from the word address
   localparam logic CSR_CURVE = 1'b0;
   localparam logic CSR_RATE  = 1'b1;

   typedef struct packed {
      logic signed [31:0] pin;
      logic signed [31:0] pout;
      logic signed [32:0] span;
      logic signed [47:0] off;
      logic signed [47:0] term;
      logic [19:0]        rrem;
      logic [19:0]        frem;
   } chan_state_type;

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      if (v[48] != v[47]) begin
         return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end
      return v[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      if (v[48:31] != {18{v[48]}}) begin
         return v[48] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end
      return v[31:0];
   endfunction

endpackage

@@ sv/asymmetric_curved_glide.sv @@
// Per-channel slew limiter with separate rise and fall glide times and a curved ramp.
//
//  port group | direction | handshake          | payload
//  req_       | in        | req_valid/req_stall| channel, sample_in, rise_ms, fall_ms, restart
//  rsp_       | out       | rsp_valid/rsp_stall| sample_out, out_channel
//  APB        | in/out    | psel/penable/pready| curve (addr 0), sample_rate_hz (addr 4)
//
// One request at a time. The bit-serial divider and multiplier set the pace: the exponential
// series runs the divider once per term (twelve terms) after a multiply.
// Reset is synchronous; channel state reads as zero until a channel is first written.
// A result waiting on rsp_stall does not block the next request from being taken; that request
// then holds in the write state until the result register drains.
`timescale 1ns / 1ps
`include "asymmetric_curved_glide_macros.svh"
module asymmetric_curved_glide #(
   parameter int CHANNELS = acg_pkg::CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_channel,
   input  logic signed [31:0] req_sample_in,
   input  logic [15:0]        req_rise_ms,
   input  logic [15:0]        req_fall_ms,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sample_out,
   output logic [3:0]         rsp_out_channel,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW = $bits(acg_pkg::chan_state_type);

   // sequencer codes
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_LOAD     = 5'd1;
   localparam logic [4:0] S_DECIDE   = 5'd2;
   localparam logic [4:0] S_CNT      = 5'd3;
   localparam logic [4:0] S_EXP_MUL  = 5'd4;
   localparam logic [4:0] S_EXP_T    = 5'd5;
   localparam logic [4:0] S_EXP_TM   = 5'd6;
   localparam logic [4:0] S_EXP_TD   = 5'd7;
   localparam logic [4:0] S_EXP_DIV  = 5'd8;
   localparam logic [4:0] S_EXP_FIN  = 5'd9;
   localparam logic [4:0] S_BDIV     = 5'd10;
   localparam logic [4:0] S_BWAIT    = 5'd11;
   localparam logic [4:0] S_BFIN     = 5'd12;
   localparam logic [4:0] S_GARG     = 5'd13;
   localparam logic [4:0] S_BMUL     = 5'd14;
   localparam logic [4:0] S_BMWAIT   = 5'd15;
   localparam logic [4:0] S_EOUT     = 5'd16;
   localparam logic [4:0] S_LIN      = 5'd17;
   localparam logic [4:0] S_WRITE    = 5'd18;

   // where the exponential hands back to
   localparam logic EXP_RET_OFFSET = 1'b0;
   localparam logic EXP_RET_STEP   = 1'b1;

   // ---------------------------------------------------------------- registers
   logic [4:0]               state_ff, state_in;
   logic [IW-1:0]            ch_ff, ch_in;
   logic [3:0]               chf_ff, chf_in;
   logic signed [31:0]       x_ff, x_in;
   logic [15:0]              rise_ff, rise_in, fall_ff, fall_in;
   logic                     restart_ff, restart_in;
   acg_pkg::chan_state_type  st_ff, st_in;
   logic                     chg_ff, chg_in, dir_ff, dir_in;
   logic [19:0]              n_ff, n_in;
   logic                     exp_neg_ff, exp_neg_in, exp_ret_ff, exp_ret_in;
   logic signed [39:0]       t_ff, t_in;
   logic signed [7:0]        k_ff, k_in;
   logic [29:0]              y_ff, y_in;
   logic [30:0]              term_ff, term_in, tprod_ff, tprod_in;
   logic [31:0]              sum_ff, sum_in;
   logic [3:0]               i_ff, i_in;
   logic [62:0]              e_ff, e_in;
   logic                     bneg_ff, bneg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_sample_ff, rsp_sample_in;
   logic [3:0]               rsp_chan_ff, rsp_chan_in;
   logic signed [15:0]       curve_ff, curve_in;
   logic [17:0]              rate_ff, rate_in;
   logic [CHANNELS-1:0]      valid_ff, valid_in;
   logic                     rd_vld_ff, rd_vld_in;

   // shared bit-serial divider
   logic                     div_busy_ff, div_busy_in;
   logic [5:0]               div_cnt_ff, div_cnt_in;
   logic [62:0]              div_num_ff, div_num_in, div_quo_ff, div_quo_in;
   logic [61:0]              div_den_ff, div_den_in, div_rem_ff, div_rem_in;
   // shared bit-serial multiplier
   logic                     mul_busy_ff, mul_busy_in;
   logic [5:0]               mul_cnt_ff, mul_cnt_in;
   logic [47:0]              mul_cand_ff, mul_cand_in;
   logic [110:0]             mul_p_ff, mul_p_in;

   // ---------------------------------------------------------------- wires
   logic                     accept, rsp_take, cfg_wr;
   logic [IW-1:0]            ch_map [16];
   logic [SW-1:0]            ram_rdata;
   logic                     ram_we;
   logic                     div_go, mul_go;
   logic [62:0]              div_a, mul_b;
   logic [61:0]              div_b;
   logic [5:0]               div_len;
   logic [47:0]              mul_a;
   logic signed [32:0]       delta, span_sel;
   logic [15:0]              ms_sel, cmag;
   logic [34:0]              cnt_num;
   logic [19:0]              n_calc, rem_sel;
   logic [32:0]              span_mag;
   logic [63:0]              tsh;
   logic [39:0]              tmag;
   logic [59:0]              yprod;
   logic [60:0]              tp_full;
   logic [30:0]              qterm;
   logic [63:0]              esh;
   logic [7:0]               nk;
   logic signed [63:0]       dval;
   logic [61:0]              dmag;
   logic signed [47:0]       bval, gterm;
   logic [46:0]              rmag;
   logic signed [48:0]       wide;
   logic signed [33:0]       lin_q;
   logic [62:0]              trial;
   logic                     ge;
   logic [48:0]              madd;

   // channel fold: numbers past the last channel wrap round
   for (genvar g = 0; g < 16; g++) begin : g_chmap
      assign ch_map[g] = IW'(g % CHANNELS);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_chan_ff;

   // ---------------------------------------------------------------- config port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         acg_pkg::CSR_CURVE: prdata = {{16{curve_ff[15]}}, curve_ff};
         acg_pkg::CSR_RATE:  prdata = {14'b0, rate_ff};
         default:            prdata = 32'b0;
      endcase
   end

   always_comb begin
      curve_in = curve_ff;
      rate_in  = rate_ff;
      if (cfg_wr) begin
         case (paddr[2])
            acg_pkg::CSR_CURVE: curve_in = pwdata[15:0];
            acg_pkg::CSR_RATE:  rate_in  = pwdata[17:0];
            default:            curve_in = curve_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- state store
   acg_ram #(
      .WIDTH (SW),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ch_ff),
      .wr_data (st_ff),
      .rd_en   (accept),
      .rd_addr (ch_map[req_channel]),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      chf_in        = chf_ff;
      x_in          = x_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      restart_in    = restart_ff;
      st_in         = st_ff;
      chg_in        = chg_ff;
      dir_in        = dir_ff;
      n_in          = n_ff;
      exp_neg_in    = exp_neg_ff;
      exp_ret_in    = exp_ret_ff;
      t_in          = t_ff;
      k_in          = k_ff;
      y_in          = y_ff;
      term_in       = term_ff;
      tprod_in      = tprod_ff;
      sum_in        = sum_ff;
      i_in          = i_ff;
      e_in          = e_ff;
      bneg_in       = bneg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      valid_in      = valid_ff;
      rd_vld_in     = rd_vld_ff;
      ram_we        = 1'b0;
      div_go        = 1'b0;
      div_a         = '0;
      div_b         = '0;
      div_len       = '0;
      mul_go        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      delta    = 33'(x_ff) - 33'(st_ff.pout);
      span_sel = (x_ff != st_ff.pin) ? delta : st_ff.span;
      ms_sel   = (!span_sel[32] && (span_sel != 33'sd0)) ? rise_ff : fall_ff;
      cnt_num  = 35'(ms_sel) * 35'(rate_ff) + 35'(acg_pkg::COUNT_BIAS);
      n_calc   = (div_quo_ff[62:20] != '0) ? acg_pkg::NMAX : div_quo_ff[19:0];
      rem_sel  = dir_ff ? st_ff.rrem : st_ff.frem;
      cmag     = curve_ff[15] ? 16'(-curve_ff) : 16'(curve_ff);
      span_mag = st_ff.span[32] ? 33'(-st_ff.span) : 33'(st_ff.span);
      tsh      = exp_neg_ff ? ((64'(mul_p_ff[62:0]) + 64'h3FF_FFFF) >> 26)
                            : (64'(mul_p_ff[62:0]) >> 26);
      tmag     = tsh[39:0];
      yprod    = t_ff[29:0] * acg_pkg::LN2_Q30;
      tp_full  = term_ff * y_ff;
      qterm    = div_quo_ff[30:0];
      nk       = 8'(-k_ff);
      esh      = {32'b0, sum_ff} << k_ff[4:0];
      dval     = 64'sh4000_0000 - $signed({1'b0, e_ff});
      dmag     = dval[63] ? 62'(-dval) : 62'(dval);
      bval     = '0;
      gterm    = '0;
      rmag     = div_quo_ff[46:0];
      wide     = '0;
      lin_q    = st_ff.span[32] ? -$signed({1'b0, div_quo_ff[32:0]})
                                :  $signed({1'b0, div_quo_ff[32:0]});

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_in      = ch_map[req_channel];
               chf_in     = req_channel;
               x_in       = req_sample_in;
               rise_in    = req_rise_ms;
               fall_in    = req_fall_ms;
               restart_in = req_restart;
               rd_vld_in  = valid_ff[ch_map[req_channel]];
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            st_in    = rd_vld_ff ? acg_pkg::chan_state_type'(ram_rdata) : '0;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (restart_ff) begin
               st_in.rrem = '0;
               st_in.frem = '0;
               st_in.pout = x_ff;
               st_in.pin  = x_ff;
               state_in   = S_WRITE;
            end else begin
               chg_in = (x_ff != st_ff.pin);
               dir_in = !span_sel[32] && (span_sel != 33'sd0);
               if (x_ff != st_ff.pin) begin
                  st_in.span = delta;
               end
               // glide time to a step count (ms * rate / 16000), rounded
               div_go   = 1'b1;
               div_a    = 63'(cnt_num);
               div_b    = 62'(acg_pkg::COUNT_DIV);
               div_len  = 6'd35;
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            if (!div_busy_ff) begin
               n_in = n_calc;
               if (chg_ff) begin
                  // new target: exp of the full curve sets the ramp scale
                  exp_neg_in = curve_ff[15];
                  exp_ret_in = EXP_RET_OFFSET;
                  mul_go     = 1'b1;
                  mul_a      = 48'({cmag, 20'b0});
                  mul_b      = 63'(acg_pkg::LOG2E_Q26);
                  state_in   = S_EXP_MUL;
               end else if (rem_sel == '0) begin
                  st_in.pout = x_ff;
                  st_in.pin  = x_ff;
                  state_in   = S_WRITE;
               end else begin
                  if (dir_ff) begin
                     st_in.rrem = st_ff.rrem - 20'd1;
                  end else begin
                     st_in.frem = st_ff.frem - 20'd1;
                  end
                  if (n_calc == '0) begin
                     // count fell to zero mid-ramp: jump to the target
                     st_in.pout = x_ff;
                     st_in.pin  = x_ff;
                     state_in   = S_WRITE;
                  end else if (curve_ff >= 16'sd2 || curve_ff <= -16'sd2) begin
                     div_go   = 1'b1;
                     div_a    = 63'({cmag, 20'b0});
                     div_b    = 62'(n_calc);
                     div_len  = 6'd36;
                     state_in = S_GARG;
                  end else begin
                     div_go   = 1'b1;
                     div_a    = 63'(span_mag);
                     div_b    = 62'(n_calc);
                     div_len  = 6'd33;
                     state_in = S_LIN;
                  end
               end
            end
         end
         S_EXP_MUL: begin
            if (!mul_busy_ff) begin
               // base-two exponent, floored
               t_in     = exp_neg_ff ? -$signed(tmag) : $signed(tmag);
               state_in = S_EXP_T;
            end
         end
         S_EXP_T: begin
            k_in     = t_ff[37:30];
            y_in     = yprod[59:30];
            term_in  = acg_pkg::ONE_Q;
            sum_in   = 32'(acg_pkg::ONE_Q);
            i_in     = 4'd1;
            state_in = S_EXP_TM;
         end
         S_EXP_TM: begin
            tprod_in = tp_full[60:30];
            state_in = S_EXP_TD;
         end
         S_EXP_TD: begin
            div_go   = 1'b1;
            div_a    = 63'(tprod_ff);
            div_b    = 62'(i_ff);
            div_len  = 6'd31;
            state_in = S_EXP_DIV;
         end
         S_EXP_DIV: begin
            if (!div_busy_ff) begin
               term_in = qterm;
               sum_in  = sum_ff + 32'(qterm);
               if (i_ff == acg_pkg::EXP_TERMS) begin
                  state_in = S_EXP_FIN;
               end else begin
                  i_in     = i_ff + 4'd1;
                  state_in = S_EXP_TM;
               end
            end
         end
         S_EXP_FIN: begin
            if (!k_ff[7]) begin
               if (k_ff > 8'sd31 || esh > 64'(acg_pkg::EXP_CAP)) begin
                  e_in = acg_pkg::EXP_CAP;
               end else begin
                  e_in = esh[62:0];
               end
            end else begin
               e_in = 63'({31'b0, sum_ff} >> nk[5:0]);
            end
            state_in = (exp_ret_ff == EXP_RET_STEP) ? S_BMUL : S_BDIV;
         end
         S_BDIV: begin
            if (dval == 64'sd0) begin
               st_in.term = '0;
               state_in   = S_BFIN;
            end else begin
               bneg_in  = st_ff.span[32] ^ dval[63];
               div_go   = 1'b1;
               div_a    = {span_mag, 30'b0};
               div_b    = dmag;
               div_len  = 6'd63;
               state_in = S_BWAIT;
            end
         end
         S_BWAIT: begin
            if (!div_busy_ff) begin
               if (bneg_ff) begin
                  if (div_quo_ff[62:48] != '0 || (div_quo_ff[47] && div_quo_ff[46:0] != '0)) begin
                     bval = {1'b1, 47'b0};
                  end else begin
                     bval = -$signed(div_quo_ff[47:0]);
                  end
               end else begin
                  if (div_quo_ff[62:47] != '0) begin
                     bval = {1'b0, {47{1'b1}}};
                  end else begin
                     bval = $signed(div_quo_ff[47:0]);
                  end
               end
               st_in.term = bval;
               state_in   = S_BFIN;
            end
         end
         S_BFIN: begin
            wide      = 49'(st_ff.pout) + 49'(st_ff.term);
            st_in.off = acg_pkg::sat48(wide);
            st_in.pin = x_ff;
            if (n_ff == '0) begin
               st_in.pout = x_ff;
               if (dir_ff) begin
                  st_in.rrem = '0;
               end else begin
                  st_in.frem = '0;
               end
            end else begin
               if (dir_ff) begin
                  st_in.rrem = n_ff - 20'd1;
               end else begin
                  st_in.frem = n_ff - 20'd1;
               end
            end
            state_in = S_WRITE;
         end
         S_GARG: begin
            if (!div_busy_ff) begin
               // per-sample decay exponent curve / n
               exp_neg_in = curve_ff[15];
               exp_ret_in = EXP_RET_STEP;
               mul_go     = 1'b1;
               mul_a      = 48'(div_quo_ff[35:0]);
               mul_b      = 63'(acg_pkg::LOG2E_Q26);
               state_in   = S_EXP_MUL;
            end
         end
         S_BMUL: begin
            bneg_in  = st_ff.term[47];
            mul_go   = 1'b1;
            mul_a    = st_ff.term[47] ? 48'(-st_ff.term) : 48'(st_ff.term);
            mul_b    = e_ff;
            state_in = S_BMWAIT;
         end
         S_BMWAIT: begin
            if (!mul_busy_ff) begin
               rmag       = (mul_p_ff[110:77] != '0) ? {47{1'b1}} : mul_p_ff[76:30];
               gterm      = bneg_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
               st_in.term = gterm;
               state_in   = S_EOUT;
            end
         end
         S_EOUT: begin
            wide       = 49'(st_ff.off) - 49'(st_ff.term);
            st_in.pout = acg_pkg::sat32(wide);
            state_in   = S_WRITE;
         end
         S_LIN: begin
            if (!div_busy_ff) begin
               wide       = 49'(st_ff.pout) + 49'(lin_q);
               st_in.pout = acg_pkg::sat32(wide);
               state_in   = S_WRITE;
            end
         end
         S_WRITE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_take) begin
               ram_we         = 1'b1;
               valid_in[ch_ff] = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = st_ff.pout;
               rsp_chan_in    = chf_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- divider datapath
   // restoring divide, one quotient bit a cycle, dividend pre-aligned to its length
   always_comb begin
      trial       = {div_rem_ff, div_num_ff[62]};
      ge          = (trial >= {1'b0, div_den_ff});
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_num_in  = div_num_ff;
      div_den_in  = div_den_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      if (div_go) begin
         div_busy_in = 1'b1;
         div_cnt_in  = div_len;
         div_num_in  = div_a << (6'd63 - div_len);
         div_den_in  = div_b;
         div_rem_in  = '0;
         div_quo_in  = '0;
      end else if (div_busy_ff) begin
         div_rem_in  = ge ? 62'(trial - {1'b0, div_den_ff}) : trial[61:0];
         div_quo_in  = {div_quo_ff[61:0], ge};
         div_num_in  = {div_num_ff[61:0], 1'b0};
         div_cnt_in  = div_cnt_ff - 6'd1;
         div_busy_in = (div_cnt_ff != 6'd1);
      end
   end

   // ---------------------------------------------------------------- multiplier datapath
   // shift-add, one multiplier bit a cycle
   always_comb begin
      madd        = {1'b0, mul_p_ff[110:63]} + (mul_p_ff[0] ? {1'b0, mul_cand_ff} : 49'b0);
      mul_busy_in = mul_busy_ff;
      mul_cnt_in  = mul_cnt_ff;
      mul_cand_in = mul_cand_ff;
      mul_p_in    = mul_p_ff;
      if (mul_go) begin
         mul_busy_in = 1'b1;
         mul_cnt_in  = 6'd63;
         mul_cand_in = mul_a;
         mul_p_in    = {48'b0, mul_b};
      end else if (mul_busy_ff) begin
         mul_p_in    = {madd, mul_p_ff[62:1]};
         mul_cnt_in  = mul_cnt_ff - 6'd1;
         mul_busy_in = (mul_cnt_ff != 6'd1);
      end
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         div_busy_ff  <= 1'b0;
         mul_busy_ff  <= 1'b0;
         curve_ff     <= acg_pkg::CURVE_RESET;
         rate_ff      <= acg_pkg::RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         div_busy_ff  <= div_busy_in;
         mul_busy_ff  <= mul_busy_in;
         curve_ff     <= curve_in;
         rate_ff      <= rate_in;
      end
      ch_ff         <= ch_in;
      chf_ff        <= chf_in;
      x_ff          <= x_in;
      rise_ff       <= rise_in;
      fall_ff       <= fall_in;
      restart_ff    <= restart_in;
      st_ff         <= st_in;
      chg_ff        <= chg_in;
      dir_ff        <= dir_in;
      n_ff          <= n_in;
      exp_neg_ff    <= exp_neg_in;
      exp_ret_ff    <= exp_ret_in;
      t_ff          <= t_in;
      k_ff          <= k_in;
      y_ff          <= y_in;
      term_ff       <= term_in;
      tprod_ff      <= tprod_in;
      sum_ff        <= sum_in;
      i_ff          <= i_in;
      e_ff          <= e_in;
      bneg_ff       <= bneg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rd_vld_ff     <= rd_vld_in;
      div_cnt_ff    <= div_cnt_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      mul_cnt_ff    <= mul_cnt_in;
      mul_cand_ff   <= mul_cand_in;
      mul_p_ff      <= mul_p_in;
   end

   // ---------------------------------------------------------------- checks
   `ACG_ASSERT_HOLDS(a_div_free, !(div_go && div_busy_ff), "divider restarted while busy")
   `ACG_ASSERT_HOLDS(a_mul_free, !(mul_go && mul_busy_ff), "multiplier restarted while busy")
   `ACG_ASSERT_NEXT(a_accept_load, accept, state_ff == S_LOAD, "request taken without load")
   `ACG_ASSERT_NEXT(a_result_out, ram_we, rsp_valid_ff, "state written without a result")

endmodule

@@ sv/acg_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module acg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
